FILE: src/hqr_pkg.sv
// Shared types, codes and saturating arithmetic helpers for the Householder QR block.
package hqr_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_ROWS_DEF  = 8;
    localparam int MAX_COLS_DEF  = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Command codes of an input transfer.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // Status codes of a result transfer.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHAPE = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_NORM_RD,
        S_NORM_MUL,
        S_NORM_ACC,
        S_SQRT,
        S_X0,
        S_VNS_MUL,
        S_VNS_ACC,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_DIV_CHK,
        S_DIV,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR,
        S_CLR,
        S_DONE
    } hqr_state_t;

    // Unsigned 64-bit add that sticks at all ones.
    function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Signed 64-bit add saturating symmetrically at +-(2^63-1).
    function automatic logic signed [63:0] sadd_sat(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(S64_MAX))
            return S64_MAX;
        else if (s < -65'(S64_MAX))
            return -S64_MAX;
        else
            return s[63:0];
    endfunction

    // Clamp a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        if (x > 65'(S32_MAX))
            return S32_MAX;
        else if (x < 65'(S32_MIN))
            return S32_MIN;
        else
            return x[31:0];
    endfunction

endpackage

FILE: src/hqr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: src/householder_qr_decomposition.sv
// Top level of the Householder QR block: command decode, sequencer and shared datapath.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  in      | in_valid, in_stall, cmd, row_index, col_index,        | in
//          | matrix_select, elem_value                            |
//  out     | out_valid, out_stall, read_value, status             | out
//  cfg     | cfg_wr_en, cfg_index, cfg_data                        | in
//
// Load, no-op and error items answer directly; a read passes S_READ (registered RAM read).
// A run takes per column k (len = m-k): the norm over len rows, the square-root steps,
// |v|^2, then for each of (n-k) columns and m rows of Q a dot product, a divide and
// an update over len rows, plus (m-k-1) clears.
// The single 32x32 multiplier and the one-bit-per-cycle divider set the pace of a run.
// Reset empties the output register and returns Q to identity; no clearing pass is needed.
// A result waiting under out_stall holds; a new item is taken once the result leaves.
module householder_qr_decomposition
    import hqr_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [2:0]         row_index,
    input  logic [2:0]         col_index,
    input  logic               matrix_select,
    input  logic signed [31:0] elem_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data
);

    localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int WD   = MAX_ROWS * MAX_COLS;
    localparam int QD   = MAX_ROWS * MAX_ROWS;
    localparam int WAW  = $clog2(WD);
    localparam int QAW  = $clog2(QD);
    localparam int NW   = 64 + FRAC_BITS + 1;
    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

    // Element address of the working matrix.
    function automatic logic [WAW-1:0] w_addr(input logic [CW:0] r, input logic [CW:0] c);
        return WAW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // Element address of Q.
    function automatic logic [QAW-1:0] q_addr(input logic [CW:0] r, input logic [CW:0] c);
        return QAW'(32'(r) * MAX_ROWS + 32'(c));
    endfunction

    // Product rescaled to Q.F with its magnitude truncated.
    function automatic logic signed [63:0] mul_q(input logic signed [63:0] p);
        logic [63:0] mag;
        mag = p[63] ? 64'(-p) : 64'(p);
        mag = mag >> FRAC_BITS;
        return p[63] ? -$signed(mag) : $signed(mag);
    endfunction

    hqr_state_t state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] read_value_reg, read_value_next;
    logic [1:0]         status_reg, status_next;
    logic [3:0]         row_count_reg, col_count_reg;
    logic [QD-1:0]      qv_reg, qv_next;
    logic               q_hit_reg, q_hit_next;
    logic               q_diag_reg, q_diag_next;
    logic [CW-1:0]      k_reg, k_next, t_reg, t_next, j_reg, j_next;
    logic               q_phase_reg, q_phase_next;
    logic               sel_reg, sel_next;
    logic signed [31:0] refl_reg [MAX_ROWS];
    logic signed [31:0] refl_next [MAX_ROWS];
    logic signed [63:0] prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        vns_reg, vns_next;
    logic signed [63:0] dot_reg, dot_next;
    logic [63:0]        sq_x_reg, sq_x_next;
    logic [33:0]        sq_rem_reg, sq_rem_next;
    logic [31:0]        sq_root_reg, sq_root_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [63:0]        div_rem_reg, div_rem_next;
    logic [30:0]        num_lo_reg, num_lo_next;
    logic [30:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] e_reg, e_next;

    // Memory ports.
    logic               w_we, w_re, q_we, q_re;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic [QAW-1:0]     q_waddr, q_raddr;
    logic signed [31:0] w_wdata, q_wdata;
    logic [31:0]        w_rdata, q_rdata;
    logic               q_rdiag;

    // Shared multiplier.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    // Decoded conditions.
    logic [CW-1:0]      m_eff, n_eff;
    logic               shape_err, in_accept;
    logic               load_ok, q_rd_ok, r_rd_ok;
    logic [CW:0]        rt;
    logic               last_t, col_end, row_end, k_end, k_below;
    logic signed [31:0] mem_data, q_data, refl_t;
    logic               div_sat, div_ge, sq_ge;
    logic [64:0]        div_r2;
    logic [NW-1:0]      num;
    logic [63:0]        num_hi, dot_mag;
    logic [35:0]        sq_rem2;
    logic [31:0]        nrm;
    logic [63:0]        acc_sum;
    logic signed [63:0] dot_sum;

    hqr_ram #(.WIDTH(32), .DEPTH(WD)) u_work_ram (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_en   (w_re),
        .rd_addr (w_raddr),
        .rd_data (w_rdata)
    );

    hqr_ram #(.WIDTH(32), .DEPTH(QD)) u_q_ram (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (q_wdata),
        .rd_en   (q_re),
        .rd_addr (q_raddr),
        .rd_data (q_rdata)
    );

    // Effective shape, clamped to the supported range.
    always_comb
    begin
        if (row_count_reg == '0)
            m_eff = CW'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            m_eff = CW'(MAX_ROWS);
        else
            m_eff = CW'(row_count_reg);
        if (col_count_reg == '0)
            n_eff = CW'(1);
        else if (32'(col_count_reg) > MAX_COLS)
            n_eff = CW'(MAX_COLS);
        else
            n_eff = CW'(col_count_reg);
    end

    assign shape_err = (m_eff < n_eff);
    assign in_stall  = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept = in_valid && !in_stall;
    assign load_ok   = (32'(row_index) < 32'(m_eff)) && (32'(col_index) < 32'(n_eff));
    assign q_rd_ok   = load_ok;
    assign r_rd_ok   = (32'(row_index) < 32'(n_eff)) && (32'(col_index) < 32'(n_eff));

    // Loop bookkeeping.
    assign rt      = (CW + 1)'(k_reg) + (CW + 1)'(t_reg);
    assign last_t  = (32'(rt) + 1 == 32'(m_eff));
    assign col_end = (32'(j_reg) + 1 == 32'(n_eff));
    assign row_end = (32'(j_reg) + 1 == 32'(m_eff));
    assign k_end   = (32'(k_reg) + 1 == 32'(n_eff));
    assign k_below = (32'(k_reg) + 1 < 32'(m_eff));

    // An unwritten Q entry reads as the identity.
    assign q_data   = q_hit_reg ? $signed(q_rdata) : (q_diag_reg ? Q_ONE : 32'sd0);
    assign mem_data = q_phase_reg ? q_data : $signed(w_rdata);
    assign refl_t   = refl_reg[t_reg[RW-1:0]];
    assign mul_p    = mul_a * mul_b;

    // Arithmetic shared by several states.
    assign acc_sum = uadd_sat(acc_reg, prod_reg);
    assign dot_sum = sadd_sat(dot_reg, prod_reg);
    assign dot_mag = dot_reg[63] ? 64'(-dot_reg) : 64'(dot_reg);
    assign num     = {dot_mag, (FRAC_BITS + 1)'(0)};
    assign num_hi  = 64'(num[NW-1:31]);
    assign div_sat = (num_hi >= vns_reg);
    assign div_r2  = {div_rem_reg, num_lo_reg[30]};
    assign div_ge  = (div_r2 >= {1'b0, vns_reg});
    assign sq_rem2 = {sq_rem_reg, sq_x_reg[63:62]};
    assign sq_ge   = (sq_rem2 >= 36'({sq_root_reg, 2'b01}));
    assign nrm     = (sq_root_reg > 32'(S32_MAX)) ? 32'(S32_MAX) : sq_root_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_RUN && !shape_err)
                        state_next = S_NORM_RD;
                    else if (cmd == CMD_READ && !shape_err)
                    begin
                        if (matrix_select ? (r_rd_ok && row_index <= col_index) : q_rd_ok)
                            state_next = S_READ;
                    end
                end
            end
            S_READ:     state_next = S_IDLE;
            S_NORM_RD:  state_next = S_NORM_MUL;
            S_NORM_MUL: state_next = S_NORM_ACC;
            S_NORM_ACC: state_next = last_t ? S_SQRT : S_NORM_RD;
            S_SQRT:     state_next = (cnt_reg == '0) ? S_X0 : S_SQRT;
            S_X0:
            begin
                if (sq_root_reg == '0)
                    state_next = k_end ? S_DONE : S_NORM_RD;
                else
                    state_next = S_VNS_MUL;
            end
            S_VNS_MUL:  state_next = S_VNS_ACC;
            S_VNS_ACC:
            begin
                if (!last_t)
                    state_next = S_VNS_MUL;
                else if (acc_sum == '0)
                    state_next = k_end ? S_DONE : S_NORM_RD;
                else
                    state_next = S_DOT_RD;
            end
            S_DOT_RD:   state_next = S_DOT_MUL;
            S_DOT_MUL:  state_next = S_DOT_ACC;
            S_DOT_ACC:  state_next = last_t ? S_DIV_CHK : S_DOT_RD;
            S_DIV_CHK:  state_next = div_sat ? S_UPD_RD : S_DIV;
            S_DIV:      state_next = (cnt_reg == '0) ? S_UPD_RD : S_DIV;
            S_UPD_RD:   state_next = S_UPD_MUL;
            S_UPD_MUL:  state_next = S_UPD_WR;
            S_UPD_WR:
            begin
                if (!last_t)
                    state_next = S_UPD_RD;
                else if (!q_phase_reg)
                    state_next = (col_end && k_below) ? S_CLR : S_DOT_RD;
                else if (row_end)
                    state_next = k_end ? S_DONE : S_NORM_RD;
                else
                    state_next = S_DOT_RD;
            end
            S_CLR:      state_next = row_end ? S_DOT_RD : S_CLR;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and result register, by state.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        qv_next         = qv_reg;
        k_next          = k_reg;
        t_next          = t_reg;
        j_next          = j_reg;
        q_phase_next    = q_phase_reg;
        sel_next        = sel_reg;
        refl_next       = refl_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        vns_next        = vns_reg;
        dot_next        = dot_reg;
        sq_x_next       = sq_x_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;
        cnt_next        = cnt_reg;
        div_rem_next    = div_rem_reg;
        num_lo_next     = num_lo_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        c_next          = c_reg;
        e_next          = e_reg;
        w_we            = 1'b0;
        w_re            = 1'b0;
        q_we            = 1'b0;
        q_re            = 1'b0;
        w_waddr         = w_addr(rt, (CW + 1)'(j_reg));
        w_raddr         = w_addr(rt, (CW + 1)'(j_reg));
        q_waddr         = q_addr((CW + 1)'(j_reg), rt);
        q_raddr         = q_addr((CW + 1)'(j_reg), rt);
        q_rdiag         = ((CW + 1)'(j_reg) == rt);
        w_wdata         = 32'sd0;
        q_wdata         = 32'sd0;
        mul_a           = refl_t;
        mul_b           = refl_t;

        unique case (state_reg)
            S_IDLE:
            begin
                w_waddr = w_addr((CW + 1)'(row_index), (CW + 1)'(col_index));
                w_raddr = w_addr((CW + 1)'(row_index), (CW + 1)'(col_index));
                q_raddr = q_addr((CW + 1)'(row_index), (CW + 1)'(col_index));
                q_rdiag = (row_index == col_index);
                if (in_accept)
                begin
                    read_value_next = 32'sd0;
                    status_next     = ST_OK;
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (load_ok)
                            begin
                                w_we    = 1'b1;
                                w_wdata = elem_value;
                            end
                            else
                                status_next = ST_RANGE;
                        end
                        CMD_RUN:
                        begin
                            if (shape_err)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_SHAPE;
                            end
                            else
                            begin
                                qv_next  = '0;
                                k_next   = '0;
                                t_next   = '0;
                                acc_next = '0;
                            end
                        end
                        CMD_READ:
                        begin
                            sel_next = matrix_select;
                            if (shape_err)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_SHAPE;
                            end
                            else if (!matrix_select)
                            begin
                                if (q_rd_ok)
                                    q_re = 1'b1;
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    status_next    = ST_RANGE;
                                end
                            end
                            else if (!r_rd_ok)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_RANGE;
                            end
                            else if (row_index <= col_index)
                                w_re = 1'b1;
                            else
                                out_valid_next = 1'b1;
                        end
                        CMD_NOP:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                read_value_next = sel_reg ? $signed(w_rdata) : q_data;
                status_next     = ST_OK;
            end
            S_NORM_RD:
            begin
                w_re    = 1'b1;
                w_raddr = w_addr(rt, (CW + 1)'(k_reg));
            end
            S_NORM_MUL:
            begin
                refl_next[t_reg[RW-1:0]] = $signed(w_rdata);
                mul_a     = $signed(w_rdata);
                mul_b     = $signed(w_rdata);
                prod_next = mul_p;
            end
            S_NORM_ACC:
            begin
                acc_next = acc_sum;
                t_next   = t_reg + 1'b1;
                if (last_t)
                begin
                    sq_x_next    = acc_sum;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = 5'd31;
                end
            end
            S_SQRT:
            begin
                // One result bit per cycle, two radicand bits shifted in.
                sq_rem_next  = 34'(sq_ge ? sq_rem2 - 36'({sq_root_reg, 2'b01}) : sq_rem2);
                sq_root_next = {sq_root_reg[30:0], sq_ge};
                sq_x_next    = sq_x_reg << 2;
                cnt_next     = cnt_reg - 1'b1;
            end
            S_X0:
            begin
                t_next   = '0;
                acc_next = '0;
                if (sq_root_reg == '0)
                    k_next = k_reg + 1'b1;
                else if (refl_reg[0][31])
                    refl_next[0] = sat32(65'(refl_reg[0]) - $signed({33'b0, nrm}));
                else
                    refl_next[0] = sat32(65'(refl_reg[0]) + $signed({33'b0, nrm}));
            end
            S_VNS_MUL:
            begin
                prod_next = mul_p;
            end
            S_VNS_ACC:
            begin
                acc_next = acc_sum;
                t_next   = t_reg + 1'b1;
                if (last_t)
                begin
                    t_next       = '0;
                    vns_next     = acc_sum;
                    dot_next     = '0;
                    j_next       = k_reg;
                    q_phase_next = 1'b0;
                    if (acc_sum == '0)
                    begin
                        k_next   = k_reg + 1'b1;
                        acc_next = '0;
                    end
                end
            end
            S_DOT_RD:
            begin
                w_re = !q_phase_reg;
                q_re = q_phase_reg;
            end
            S_DOT_MUL:
            begin
                mul_b     = mem_data;
                prod_next = mul_p;
            end
            S_DOT_ACC:
            begin
                dot_next = dot_sum;
                t_next   = last_t ? '0 : t_reg + 1'b1;
            end
            S_DIV_CHK:
            begin
                neg_next     = dot_reg[63];
                dot_next     = '0;
                div_rem_next = num_hi;
                num_lo_next  = num[30:0];
                quo_next     = '0;
                cnt_next     = 5'd30;
                if (div_sat)
                    c_next = dot_reg[63] ? -S32_MAX : S32_MAX;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                div_rem_next = div_ge ? 64'(div_r2 - {1'b0, vns_reg}) : div_r2[63:0];
                quo_next     = {quo_reg[29:0], div_ge};
                num_lo_next  = num_lo_reg << 1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    c_next = neg_reg ? -$signed({1'b0, quo_reg[29:0], div_ge})
                                     : $signed({1'b0, quo_reg[29:0], div_ge});
            end
            S_UPD_RD:
            begin
                w_re = !q_phase_reg;
                q_re = q_phase_reg;
            end
            S_UPD_MUL:
            begin
                e_next    = mem_data;
                mul_b     = c_reg;
                prod_next = mul_p;
            end
            S_UPD_WR:
            begin
                w_wdata = sat32(65'(e_reg) - 65'(mul_q(prod_reg)));
                q_wdata = w_wdata;
                w_we    = !q_phase_reg;
                q_we    = q_phase_reg;
                if (q_phase_reg)
                    qv_next[q_waddr] = 1'b1;
                t_next = t_reg + 1'b1;
                if (last_t)
                begin
                    t_next = '0;
                    if (!q_phase_reg)
                    begin
                        if (!col_end)
                            j_next = j_reg + 1'b1;
                        else if (k_below)
                            j_next = k_reg + 1'b1;
                        else
                        begin
                            q_phase_next = 1'b1;
                            j_next       = '0;
                        end
                    end
                    else if (row_end)
                    begin
                        k_next   = k_reg + 1'b1;
                        acc_next = '0;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            S_CLR:
            begin
                // Entries below the diagonal of column k become zero.
                w_we    = 1'b1;
                w_waddr = w_addr((CW + 1)'(j_reg), (CW + 1)'(k_reg));
                if (row_end)
                begin
                    q_phase_next = 1'b1;
                    j_next       = '0;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            S_DONE:
            begin
                out_valid_next  = 1'b1;
                read_value_next = 32'sd0;
                status_next     = ST_OK;
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase

        q_hit_next  = q_re ? qv_reg[q_raddr] : q_hit_reg;
        q_diag_next = q_re ? q_rdiag : q_diag_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_count_reg <= 4'd8;
            col_count_reg <= 4'd8;
            qv_reg        <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            j_reg         <= '0;
            q_phase_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            qv_reg        <= qv_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            j_reg         <= j_next;
            q_phase_reg   <= q_phase_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_ROW_COUNT: row_count_reg <= cfg_data;
                    CFG_COL_COUNT: col_count_reg <= cfg_data;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        q_hit_reg      <= q_hit_next;
        q_diag_reg     <= q_diag_next;
        sel_reg        <= sel_next;
        refl_reg       <= refl_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        vns_reg        <= vns_next;
        dot_reg        <= dot_next;
        sq_x_reg       <= sq_x_next;
        sq_rem_reg     <= sq_rem_next;
        sq_root_reg    <= sq_root_next;
        div_rem_reg    <= div_rem_next;
        num_lo_reg     <= num_lo_next;
        quo_reg        <= quo_next;
        neg_reg        <= neg_next;
        c_reg          <= c_next;
        e_reg          <= e_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    // A run start returns every Q entry to identity.
    a_run_clears_q: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_RUN && !shape_err) |=> (qv_reg == '0))
        else $error("Q valid bits not cleared at run start");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_rem_reg < vns_reg))
        else $error("divider remainder out of range");

    // No result is pending while the sequencer iterates.
    a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_READ && state_reg != S_DONE)
            |-> !out_valid_reg)
        else $error("result pending during a run");
`endif

endmodule

FILE: bench/householder_qr_decomposition_tb.sv
// Self-checking testbench for the Householder QR block with a bit-exact predictor.
`timescale 1ns / 1ps

module householder_qr_decomposition_tb;
    import hqr_pkg::*;

    localparam int DIM  = 8;
    localparam int FRAC = 16;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         code;
    } qr_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic               matrix_select;
    logic signed [31:0] elem_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [3:0]         cfg_data;

    // Predictor state.
    logic signed [31:0] a_mat [DIM*DIM];
    logic signed [31:0] q_mat [DIM*DIM];
    logic signed [31:0] refl [DIM];
    logic [3:0]         rows_reg;
    logic [3:0]         cols_reg;

    qr_result_t pending_results [$];
    int         fail_count;
    int         items_sent;
    int         burst_left;
    int         stall_left;
    int         free_left;

    householder_qr_decomposition i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .matrix_select (matrix_select),
        .elem_value    (elem_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Fixed run limit.
    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------- arithmetic of the predictor ----------------

    function automatic logic signed [31:0] clamp32(input logic signed [64:0] x);
        if (x > 65'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -65'sh8000_0000)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [63:0] sum_sq_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic longint dot_acc_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh7FFF_FFFF_FFFF_FFFF)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (s < -65'sh7FFF_FFFF_FFFF_FFFF)
            return -64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // 2*dot/|v|^2 in Q.F with the sign of dot, its magnitude truncated and clamped to 2^31-1.
    function automatic logic signed [31:0] scale_factor(input longint dot, input logic [63:0] vns);
        logic [63:0] mag;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] carry;
        logic [63:0] bit_in;
        logic [63:0] lim;
        logic        hit;
        lim = 64'h7FFF_FFFF;
        mag = (dot < 0) ? 64'(-dot) : 64'(dot);
        r = 0;
        q = 0;
        hit = 1'b0;
        for (int i = 0; i < 64 + FRAC + 1; i++)
        begin
            if (!hit)
            begin
                bit_in = (i < 64) ? ((mag >> (63 - i)) & 64'd1) : 64'd0;
                carry = r >> 63;
                r = (r << 1) | bit_in;
                if (q > (lim >> 1))
                    hit = 1'b1;
                else
                begin
                    q = q << 1;
                    if (carry != 0 || r >= vns)
                    begin
                        r = r - vns;
                        q = q | 64'd1;
                    end
                end
            end
        end
        if (hit || q > lim)
            q = lim;
        return (dot < 0) ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

    function automatic longint fix_mul(input logic signed [31:0] a, input logic signed [31:0] b);
        longint      p;
        logic [63:0] mag;
        p = longint'(a) * longint'(b);
        mag = (p < 0) ? 64'(-p) : 64'(p);
        mag = mag >> FRAC;
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic int used_size(input logic [3:0] r);
        if (r < 1)
            return 1;
        return (r > DIM) ? DIM : int'(r);
    endfunction

    task automatic reset_q();
        for (int i = 0; i < DIM * DIM; i++)
            q_mat[i] = 0;
        for (int i = 0; i < DIM; i++)
            q_mat[i * DIM + i] = 32'sd1 <<< FRAC;
    endtask

    // Reflect column by column, updating R in place and Q from the right.
    task automatic run_qr(input int m, input int n);
        int               len;
        logic [63:0]      nsq;
        logic [63:0]      vns;
        logic [63:0]      nrm;
        longint           dot;
        logic signed [31:0] c;
        logic signed [31:0] x0;
        reset_q();
        for (int k = 0; k < n; k++)
        begin
            len = m - k;
            nsq = 0;
            vns = 0;
            for (int t = 0; t < len; t++)
            begin
                refl[t] = a_mat[(k + t) * DIM + k];
                nsq = sum_sq_sat(nsq, 64'(longint'(refl[t]) * longint'(refl[t])));
            end
            nrm = floor_sqrt(nsq);
            if (nrm > 64'h7FFF_FFFF)
                nrm = 64'h7FFF_FFFF;
            if (nrm == 0)
                continue;
            x0 = refl[0];
            if (x0 >= 0)
                refl[0] = clamp32(65'(x0) + 65'(nrm));
            else
                refl[0] = clamp32(65'(x0) - 65'(nrm));
            for (int t = 0; t < len; t++)
                vns = sum_sq_sat(vns, 64'(longint'(refl[t]) * longint'(refl[t])));
            if (vns == 0)
                continue;
            for (int j = k; j < n; j++)
            begin
                dot = 0;
                for (int t = 0; t < len; t++)
                    dot = dot_acc_sat(dot, longint'(refl[t]) * longint'(a_mat[(k + t) * DIM + j]));
                c = scale_factor(dot, vns);
                for (int t = 0; t < len; t++)
                    a_mat[(k + t) * DIM + j] =
                        clamp32(65'(a_mat[(k + t) * DIM + j]) - 65'(fix_mul(c, refl[t])));
            end
            for (int i = k + 1; i < m; i++)
                a_mat[i * DIM + k] = 0;
            for (int i = 0; i < m; i++)
            begin
                dot = 0;
                for (int t = 0; t < len; t++)
                    dot = dot_acc_sat(dot, longint'(q_mat[i * DIM + k + t]) * longint'(refl[t]));
                c = scale_factor(dot, vns);
                for (int t = 0; t < len; t++)
                    q_mat[i * DIM + k + t] =
                        clamp32(65'(q_mat[i * DIM + k + t]) - 65'(fix_mul(c, refl[t])));
            end
        end
    endtask

    // Expected result of one accepted item; updates the predictor state.
    task automatic predict_result(input logic [1:0] op, input int r, input int c,
                                  input logic sel, input logic signed [31:0] val,
                                  output qr_result_t res);
        int m;
        int n;
        m = used_size(rows_reg);
        n = used_size(cols_reg);
        res.value = 0;
        res.code = ST_OK;
        case (op)
            CMD_LOAD:
                if (r < m && c < n)
                    a_mat[r * DIM + c] = val;
                else
                    res.code = ST_RANGE;
            CMD_RUN:
                if (m < n)
                    res.code = ST_SHAPE;
                else
                    run_qr(m, n);
            CMD_READ:
                if (m < n)
                    res.code = ST_SHAPE;
                else if (sel == 1'b0)
                begin
                    if (r < m && c < n)
                        res.value = q_mat[r * DIM + c];
                    else
                        res.code = ST_RANGE;
                end
                else if (r < n && c < n)
                    res.value = (r <= c) ? a_mat[r * DIM + c] : 32'sd0;
                else
                    res.code = ST_RANGE;
            default: ;
        endcase
    endtask

    // ---------------- stimulus ----------------

    // Send one item; called and returning at a falling edge. Sender idles in bursts.
    task automatic send_item(input logic [1:0] op, input int r, input int c,
                             input logic sel, input logic signed [31:0] val);
        qr_result_t res;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
        end
        cmd = op;
        row_index = r[2:0];
        col_index = c[2:0];
        matrix_select = sel;
        elem_value = val;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_result(op, r, c, sel, val, res);
        pending_results.push_back(res);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        if (idx == CFG_ROW_COUNT)
            rows_reg = val;
        else
            cols_reg = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_shape(input logic [3:0] rr, input logic [3:0] cc);
        drain();
        write_reg(CFG_ROW_COUNT, rr);
        write_reg(CFG_COL_COUNT, cc);
    endtask

    function automatic logic signed [31:0] rand_elem();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
    endfunction

    task automatic read_all(input int m, input int n);
        for (int r = 0; r < m; r++)
            for (int c = 0; c < n; c++)
                send_item(CMD_READ, r, c, 1'b0, $urandom);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_item(CMD_READ, r, c, 1'b1, $urandom);
    endtask

    // Fill the whole 8x8 work area so that no later read meets an unwritten element.
    task automatic test_full_load();
        for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++)
                send_item(CMD_LOAD, r, c, 1'b0, rand_elem());
    endtask

    // Extremes of the element value, a 3x2 run with reads of Q and R, and a zero column.
    task automatic test_extremes();
        set_shape(4'd3, 4'd2);
        send_item(CMD_LOAD, 0, 0, 1'b0, 32'sh7FFF_FFFF);
        send_item(CMD_LOAD, 1, 0, 1'b0, 32'sh8000_0000);
        send_item(CMD_LOAD, 2, 0, 1'b0, 32'sh0000_0000);
        send_item(CMD_LOAD, 0, 1, 1'b0, 32'sh8000_0000);
        send_item(CMD_LOAD, 1, 1, 1'b0, 32'sh8000_0000);
        send_item(CMD_LOAD, 2, 1, 1'b0, 32'sh7FFF_FFFF);
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        read_all(3, 2);
        // A column of zeros is skipped.
        set_shape(4'd2, 4'd1);
        send_item(CMD_LOAD, 0, 0, 1'b0, 0);
        send_item(CMD_LOAD, 1, 0, 1'b0, 0);
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        send_item(CMD_READ, 0, 0, 1'b1, 0);
        send_item(CMD_READ, 1, 0, 1'b0, 0);
    endtask

    // Fewer rows than columns, out-of-shape indexes, R below the diagonal, no-op.
    task automatic test_errors();
        set_shape(4'd2, 4'd5);
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        send_item(CMD_READ, 0, 0, 1'b1, 0);
        send_item(CMD_LOAD, 1, 4, 1'b0, 32'sh0001_0000);
        set_shape(4'd4, 4'd3);
        send_item(CMD_LOAD, 4, 0, 1'b0, 0);
        send_item(CMD_LOAD, 0, 3, 1'b0, 0);
        send_item(CMD_READ, 3, 0, 1'b1, 0);
        send_item(CMD_READ, 2, 1, 1'b1, 0);
        send_item(CMD_READ, 4, 2, 1'b0, 0);
        send_item(CMD_READ, 3, 2, 1'b0, 0);
        send_item(CMD_NOP, 7, 7, 1'b1, 32'shFFFF_FFFF);
    endtask

    // Register values beyond the range clamp to one and to the maximum.
    task automatic test_register_clamp();
        set_shape(4'd0, 4'd0);
        send_item(CMD_LOAD, 0, 0, 1'b0, rand_elem());
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        send_item(CMD_READ, 0, 0, 1'b0, 0);
        send_item(CMD_READ, 1, 0, 1'b0, 0);
        set_shape(4'd15, 4'd9);
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        send_item(CMD_READ, 7, 7, 1'b0, 0);
        send_item(CMD_READ, 7, 7, 1'b1, 0);
    endtask

    // Random phases: new shape, well-formed load/run/read sequences with some noise.
    task automatic test_random_phases(input int target);
        int          m;
        int          n;
        int          t;
        logic [3:0]  rr;
        logic [3:0]  cc;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                rr = $urandom_range(0, 15);
                cc = $urandom_range(0, 15);
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                rr = $urandom_range(1, 8);
                cc = $urandom_range(1, 8);
            end
            else
            begin
                rr = $urandom_range(1, 4);
                cc = $urandom_range(1, 4);
            end
            if (used_size(rr) < used_size(cc) && $urandom_range(0, 5) != 0)
            begin
                rr = rr ^ cc;
                cc = rr ^ cc;
                rr = rr ^ cc;
            end
            set_shape(rr, cc);
            m = used_size(rr);
            n = used_size(cc);
            for (int r = 0; r < m; r++)
                for (int c = 0; c < n; c++)
                    send_item(CMD_LOAD, r, c, 1'b0, rand_elem());
            // Noise: any command at any index.
            repeat ($urandom_range(0, 6))
                send_item(2'($urandom_range(0, 3)), $urandom_range(0, 7),
                          $urandom_range(0, 7), 1'($urandom), rand_elem());
            send_item(CMD_RUN, 0, 0, 1'($urandom), $urandom);
            // Hold off now and then until every result is back.
            if ($urandom_range(0, 3) == 0)
                drain();
            read_all(m, n);
            t = $urandom_range(0, 4);
            repeat (t)
                send_item(CMD_READ, $urandom_range(0, 7), $urandom_range(0, 7), 1'($urandom), 0);
        end
    endtask

    // ---------------- result check ----------------

    always @(posedge clk)
    begin
        qr_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (read_value !== exp_res.value)
                begin
                    $error("read_value expected %0d actual %0d", exp_res.value, read_value);
                    fail_count++;
                end
                if (status !== exp_res.code)
                begin
                    $error("status expected %0d actual %0d", exp_res.code, status);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall pattern: free stretches and stall stretches of random length.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left <= free_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            free_left <= $urandom_range(0, 40);
            stall_left <= $urandom_range(0, 6);
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_NOP;
        row_index = 0;
        col_index = 0;
        matrix_select = 1'b0;
        elem_value = 0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_ROW_COUNT;
        cfg_data = 0;
        fail_count = 0;
        items_sent = 0;
        burst_left = 0;
        rows_reg = 4'd8;
        cols_reg = 4'd8;
        reset_q();
        for (int i = 0; i < DIM; i++)
            refl[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_full_load();
        send_item(CMD_RUN, 0, 0, 1'b0, 0);
        read_all(DIM, DIM);
        test_extremes();
        test_errors();
        test_register_clamp();
        test_random_phases(1900);

        drain();
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
